### rtl/core/oqm_pkg.sv
package oqm_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MAX_PAIRS = 8;

    localparam logic [1:0] CMD_PLACE   = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_PROCESS = 2'd2;

    localparam logic [2:0] ST_PLACED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;
    localparam logic [2:0] ST_NO_MATCH  = 3'd5;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] order_id;
        logic        is_sell;
        logic [19:0] price;
        logic [19:0] quantity;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] first_id;
        logic [31:0] second_id;
        logic        result_side;
        logic [19:0] result_price;
        logic [19:0] result_quantity;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] id;
        logic        side;
        logic [19:0] price;
        logic [19:0] quantity;
    } entry_t;

endpackage

### rtl/core/order_queue_cancel_and_pair_match_core.sv
// Order queue: place, cancel by id, and buy/sell pair matching.
// Place writes the entry when the command is taken; cancel reads and compares each entry
// from the head in turn, then moves each later entry forward to close the gap; process reads
// the first two entries and decides on a pair, once per pair checked. One command at a time;
// a stalled result holds the core. Reset: the queue is empty (count and head cleared);
// memory contents are not cleared, since no unwritten entry is used in a result.
module order_queue_cancel_and_pair_match_core #(
    parameter int DEPTH = oqm_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  oqm_pkg::in_t  cmd_data,
    output logic          res_valid,
    input  logic          res_stall,
    output oqm_pkg::out_t res_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(oqm_pkg::MAX_PAIRS + 1);

    typedef enum logic [3:0] {
        IDLE,
        EMIT,
        P_RD0,
        P_RD1,
        P_DEC,
        C_RD,
        C_CMP,
        S_RD,
        S_WR
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [PW-1:0]   npair_reg, npair_next;
    logic            pend_valid_reg, pend_valid_next;
    oqm_pkg::out_t   pend_reg, pend_next;
    oqm_pkg::entry_t e0_reg, e0_next;
    oqm_pkg::in_t    item_reg, item_next;
    oqm_pkg::out_t   res_reg, res_next;
    logic            res_valid_reg, res_valid_next;
    oqm_pkg::out_t   out_reg, out_next;

    // memory port controls
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    oqm_pkg::entry_t mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    oqm_pkg::entry_t mem_rdata;

    logic            slot_free;
    logic            emit_en;
    oqm_pkg::out_t   emit_val;
    logic            pair_ok;
    oqm_pkg::out_t   pair_res;
    logic [CW-1:0]   last_pos;

    // logical queue position to physical memory address (ring buffer)
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, i};
        if (s >= (AW + 1)'(DEPTH))
        begin
            s = s - (AW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    oqm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register frees up when empty or when its transfer completes
    assign slot_free = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = out_reg;
    assign last_pos  = count_reg - CW'(1);

    // at least two entries, head is BUY, second is SELL, room left in this command's pair budget
    assign pair_ok = (count_reg >= CW'(2)) && (e0_reg.side == oqm_pkg::SIDE_BUY)
                     && (mem_rdata.side == oqm_pkg::SIDE_SELL)
                     && (npair_reg < PW'(oqm_pkg::MAX_PAIRS));

    always_comb
    begin
        pair_res                 = '0;
        pair_res.status          = oqm_pkg::ST_DONE;
        pair_res.first_id        = e0_reg.id;
        pair_res.second_id       = mem_rdata.id;
        pair_res.result_price    = mem_rdata.price;
        pair_res.result_quantity = (e0_reg.quantity < mem_rdata.quantity)
                                   ? e0_reg.quantity : mem_rdata.quantity;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        npair_next      = npair_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        e0_next         = e0_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        emit_en         = 1'b0;
        emit_val        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = phys(head_reg, AW'(count_reg));
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = phys(head_reg, idx_reg);

        case (state_reg)
            IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next = cmd_data;
                    res_next  = '0;
                    res_next.last = 1'b1;
                    case (cmd_data.cmd)
                        oqm_pkg::CMD_PLACE:
                        begin
                            res_next.first_id = cmd_data.order_id;
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_next.status = oqm_pkg::ST_FULL;
                            end
                            else
                            begin
                                res_next.status  = oqm_pkg::ST_PLACED;
                                mem_we           = 1'b1;
                                mem_wdata.id     = cmd_data.order_id;
                                mem_wdata.side   = cmd_data.is_sell;
                                mem_wdata.price  = cmd_data.price;
                                mem_wdata.quantity = cmd_data.quantity;
                                count_next       = count_reg + CW'(1);
                            end
                            state_next = EMIT;
                        end
                        oqm_pkg::CMD_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = oqm_pkg::ST_EMPTY;
                                state_next      = EMIT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = C_RD;
                            end
                        end
                        oqm_pkg::CMD_PROCESS:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = oqm_pkg::ST_EMPTY;
                                state_next      = EMIT;
                            end
                            else
                            begin
                                npair_next      = '0;
                                pend_valid_next = 1'b0;
                                state_next      = P_RD0;
                            end
                        end
                        default:
                        begin
                            // unused code: drop, no result
                            state_next = IDLE;
                        end
                    endcase
                end
            end

            EMIT:
            begin
                if (slot_free)
                begin
                    emit_en    = 1'b1;
                    emit_val   = res_reg;
                    state_next = IDLE;
                end
            end

            P_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                state_next = P_RD1;
            end

            P_RD1:
            begin
                e0_next    = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = phys(head_reg, AW'(1));
                state_next = P_DEC;
            end

            P_DEC:
            begin
                // a pending pair goes out once we know whether another follows
                if (pend_valid_reg)
                begin
                    if (slot_free)
                    begin
                        emit_en       = 1'b1;
                        emit_val      = pend_reg;
                        emit_val.last = !pair_ok;
                        if (pair_ok)
                        begin
                            pend_next  = pair_res;
                            head_next  = phys(head_reg, AW'(2));
                            count_next = count_reg - CW'(2);
                            npair_next = npair_reg + PW'(1);
                            state_next = P_RD0;
                        end
                        else
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = IDLE;
                        end
                    end
                end
                else if (pair_ok)
                begin
                    pend_next       = pair_res;
                    pend_valid_next = 1'b1;
                    head_next       = phys(head_reg, AW'(2));
                    count_next      = count_reg - CW'(2);
                    npair_next      = npair_reg + PW'(1);
                    state_next      = P_RD0;
                end
                else if (slot_free)
                begin
                    emit_en         = 1'b1;
                    emit_val        = '0;
                    emit_val.status = oqm_pkg::ST_NO_MATCH;
                    emit_val.last   = 1'b1;
                    state_next      = IDLE;
                end
            end

            C_RD:
            begin
                mem_re     = 1'b1;
                state_next = C_CMP;
            end

            C_CMP:
            begin
                if (mem_rdata.id == item_reg.order_id)
                begin
                    if (slot_free)
                    begin
                        emit_en                  = 1'b1;
                        emit_val                 = '0;
                        emit_val.status          = oqm_pkg::ST_DONE;
                        emit_val.first_id        = mem_rdata.id;
                        emit_val.result_side     = mem_rdata.side;
                        emit_val.result_price    = mem_rdata.price;
                        emit_val.result_quantity = mem_rdata.quantity;
                        emit_val.last            = 1'b1;
                        if (CW'(idx_reg) == last_pos)
                        begin
                            count_next = last_pos;
                            state_next = IDLE;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
                else if (CW'(idx_reg) == last_pos)
                begin
                    res_next.status   = oqm_pkg::ST_NOT_FOUND;
                    res_next.first_id = item_reg.order_id;
                    state_next        = EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = C_RD;
                end
            end

            S_RD:
            begin
                // fetch the entry behind the gap
                mem_re     = 1'b1;
                mem_raddr  = phys(head_reg, idx_reg + AW'(1));
                state_next = S_WR;
            end

            S_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg);
                mem_wdata = mem_rdata;
                if (CW'(idx_reg) + CW'(1) == last_pos)
                begin
                    count_next = last_pos;
                    state_next = IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_RD;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase

        res_valid_next = emit_en ? 1'b1 : (res_valid_reg && res_stall);
        out_next       = emit_en ? emit_val : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            npair_reg      <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            pend_reg       <= '0;
            e0_reg         <= '0;
            item_reg       <= '0;
            res_reg        <= '0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            npair_reg      <= npair_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            pend_reg       <= pend_next;
            e0_reg         <= e0_next;
            item_reg       <= item_next;
            res_reg        <= res_next;
            out_reg        <= out_next;
        end
    end

endmodule

### rtl/core/oqm_ram.sv
module oqm_ram #(
    parameter int DEPTH = oqm_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  oqm_pkg::entry_t  wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output oqm_pkg::entry_t  rdata
);

    oqm_pkg::entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, hold data when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/oqm_checker.sv
module oqm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input oqm_pkg::in_t  cmd_data,
    input logic          res_valid,
    input logic          res_stall,
    input oqm_pkg::out_t res_data
);

    // a stalled command holds until its transfer
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_data))
        else $error("command changed while stalled");

    // a stalled result holds until its transfer
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.status <= oqm_pkg::ST_NO_MATCH)
        else $error("status code out of range");

    // only a match carries a sell id
    a_second_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status != oqm_pkg::ST_DONE) |-> res_data.second_id == '0)
        else $error("second id set on a non-match result");

    // every status but a match or cancel is a single, final result
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status != oqm_pkg::ST_DONE) |-> res_data.last)
        else $error("single result without last");

endmodule

bind order_queue_cancel_and_pair_match_core oqm_checker u_oqm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
